@@ rtl/clb_pkg.sv @@
// Shared types and constants for the contact Laplacian builder.
package clb_pkg;

	// Fixed field widths of the stream beats and registers
	localparam int COORD_IN_W  = 20;
	localparam int IDX_W       = 10;
	localparam int DEG_W       = 10;
	localparam int CUTOFF_W    = 44;
	localparam int WEIGHT_W    = 16;
	localparam int ENTRY_W     = 27;
	localparam int COUNT_OUT_W = 11;
	localparam int S_DATA_W    = 80;
	localparam int M_DATA_W    = 40;
	localparam int CFG_IDX_W   = 1;

	localparam logic [DEG_W-1:0]    DEG_MAX    = 10'd1023;
	localparam logic [CUTOFF_W-1:0] CUTOFF_RST = 44'd3211264;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd256;

	// Register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 1'b1;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_QUERY = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_INDEX = 2'd1,
		STAT_DROPPED   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_COMMIT,
		S_QREF,
		S_QCOL,
		S_QWAIT,
		S_RESP
	} fsm_t;

endpackage

@@ rtl/clb_dist.sv @@
// Three-stage squared-distance compare of two 3-D points against the cutoff.
module clb_dist #(
	parameter int COORD_BITS = 20,
	parameter int TAG_W      = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [3*COORD_BITS-1:0]        a_pt,     // x, y, z from the lowest bit up
	input  logic [3*COORD_BITS-1:0]        b_pt,     // x, y, z from the lowest bit up
	input  logic [TAG_W-1:0]               in_tag,
	input  logic [clb_pkg::CUTOFF_W-1:0]   cutoff,
	output logic                           out_valid,
	output logic                           out_touch,
	output logic [TAG_W-1:0]               out_tag,
	output logic                           busy
);

	localparam int CB    = COORD_BITS;
	localparam int DW    = CB + 1;
	// |a-b| never exceeds 2^CB-1, so it fits in CB bits when CB reaches 32
	localparam int MW    = (DW > 32) ? 32 : DW;
	localparam int SQW   = 2 * MW;
	localparam int CW    = clb_pkg::CUTOFF_W;
	localparam int SQX   = (SQW > CW + 1) ? SQW : CW + 1;
	localparam int SUM_W = CW + 2;

	logic             v_s1, v_s2, v_s3;
	logic [TAG_W-1:0] tag_s1, tag_s2, tag_s3;
	logic [MW-1:0]    mag_s1 [3];
	logic [CW-1:0]    sq_s2 [3];
	logic             far_s2;
	logic             touch_s3;

	logic [MW-1:0]    mag_c [3];
	logic [CW-1:0]    sq_c [3];
	logic             far_c;
	logic             touch_c;

	// Stage 1: per-axis absolute difference
	always_comb begin
		logic [CB-1:0]        ak;
		logic [CB-1:0]        bk;
		logic signed [DW-1:0] d;
		logic [DW-1:0]        m;
		ak = '0;
		bk = '0;
		d  = '0;
		m  = '0;
		for (int k = 0; k < 3; k++) begin
			ak = a_pt[k*CB +: CB];
			bk = b_pt[k*CB +: CB];
			d  = $signed({ak[CB-1], ak}) - $signed({bk[CB-1], bk});
			m  = d[DW-1] ? (~d + DW'(1)) : d;
			mag_c[k] = MW'(m);
		end
	end

	// Stage 2: squares; anything at or above 2^44 can never touch
	always_comb begin
		logic [SQW-1:0] sq;
		logic [SQX-1:0] sqx;
		sq    = '0;
		sqx   = '0;
		far_c = 1'b0;
		for (int k = 0; k < 3; k++) begin
			sq       = mag_s1[k] * mag_s1[k];
			sqx      = SQX'(sq);
			far_c    = far_c | (|sqx[SQX-1:CW]);
			sq_c[k]  = sqx[CW-1:0];
		end
	end

	// Stage 3: sum and compare
	always_comb begin
		logic [SUM_W-1:0] sum;
		sum     = SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);
		touch_c = !far_s2 && (sum <= SUM_W'(cutoff));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1   <= in_tag;
		tag_s2   <= tag_s1;
		tag_s3   <= tag_s2;
		mag_s1   <= mag_c;
		sq_s2    <= sq_c;
		far_s2   <= far_c;
		touch_s3 <= touch_c;
	end

	assign out_valid = v_s3;
	assign out_touch = touch_s3;
	assign out_tag   = tag_s3;
	assign busy      = v_s1 | v_s2 | v_s3;

endmodule

@@ rtl/contact_laplacian_builder_core.sv @@
// Top level: point store, contact scan and Kirchhoff entry queries.
//
//  port group   dir  beat contents
//  s_*          in   tuser: opcode; tdata: x, y, z, row_index, col_index
//  m_*          out  tdata: entry_value, status, point_count
//  cfg_*        in   register write: 0 cutoff_squared, 1 contact_weight
//
// One item at a time. Clear, an ignored opcode and a load on a full store finish
// in the idle state. A load reads every stored point through the one coordinate
// memory port, one per cycle, then drains the compare and commits the point.
// A query makes two memory reads and runs the 3-stage compare; one with a bad
// index skips both. Its result may then wait on m_tready.
// No clearing pass after reset.
module contact_laplacian_builder_core #(
	parameter int MAX_POINTS = 1024,
	parameter int COORD_BITS = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// x_coord[19:0], y_coord[39:20], z_coord[59:40], row_index[69:60], col_index[79:70]
	input  logic [clb_pkg::S_DATA_W-1:0]      s_tdata,
	// opcode[1:0]
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// entry_value[26:0], status[28:27], point_count[39:29]
	output logic [clb_pkg::M_DATA_W-1:0]      m_tdata,
	input  logic                              cfg_we,
	input  logic [clb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [clb_pkg::CUTOFF_W-1:0]      cfg_data
);

	localparam int AW    = $clog2(MAX_POINTS);
	localparam int CW    = $clog2(MAX_POINTS + 1);
	localparam int XW    = (CW > clb_pkg::IDX_W) ? CW : clb_pkg::IDX_W;
	localparam int CXW   = (COORD_BITS > clb_pkg::COORD_IN_W) ? COORD_BITS : clb_pkg::COORD_IN_W;
	localparam int CRW   = 3 * COORD_BITS;
	localparam int DEG_W = clb_pkg::DEG_W;
	localparam int TAG_W = AW + DEG_W;
	localparam int EW    = clb_pkg::ENTRY_W;

	// Input beat fields
	logic [clb_pkg::COORD_IN_W-1:0] x_f, y_f, z_f;
	logic [clb_pkg::IDX_W-1:0]      row_f, col_f;
	logic [CXW-1:0]                 x_ext, y_ext, z_ext;
	logic [CRW-1:0]                 pt_in;
	clb_pkg::opcode_t               op;
	logic                           s_acc;
	logic                           full;
	logic                           q_bad;

	assign x_f   = s_tdata[19:0];
	assign y_f   = s_tdata[39:20];
	assign z_f   = s_tdata[59:40];
	assign row_f = s_tdata[69:60];
	assign col_f = s_tdata[79:70];
	assign op    = clb_pkg::opcode_t'(s_tuser);
	assign x_ext = CXW'($signed(x_f));
	assign y_ext = CXW'($signed(y_f));
	assign z_ext = CXW'($signed(z_f));
	assign pt_in = {z_ext[COORD_BITS-1:0], y_ext[COORD_BITS-1:0], x_ext[COORD_BITS-1:0]};

	// Control state
	clb_pkg::fsm_t                 state_q, state_d;
	logic [CW-1:0]                 count_q;
	logic                          ovf_q;
	logic [clb_pkg::CUTOFF_W-1:0]  cutoff_q;
	logic [clb_pkg::WEIGHT_W-1:0]  weight_q;
	logic [CW-1:0]                 scan_idx_q;
	logic                          cmp_issue_q;
	logic                          out_valid_q;

	// Payload registers
	logic [CRW-1:0]                ref_q;
	logic [AW-1:0]                 rd_addr_q;
	logic [DEG_W-1:0]              new_deg_q;
	logic [AW-1:0]                 row_q, col_q;
	logic                          diag_q, bad_q, touch_q;
	logic [DEG_W-1:0]              qdeg_q;
	logic [EW-1:0]                 out_value_q;
	clb_pkg::status_t              out_status_q;
	logic [clb_pkg::COUNT_OUT_W-1:0] out_count_q;

	// Memories
	logic [CRW-1:0]   coord_mem [MAX_POINTS];
	logic [DEG_W-1:0] deg_mem   [MAX_POINTS];
	logic [CRW-1:0]   coord_rdata;
	logic [DEG_W-1:0] deg_rdata;

	// Datapath control
	logic             rd_en, rd_cmp;
	logic [AW-1:0]    rd_addr;
	logic             coord_we;
	logic             deg_we;
	logic [AW-1:0]    deg_waddr;
	logic [DEG_W-1:0] deg_wdata;
	logic             out_free;
	logic             pipe_busy;
	logic             scan_done;

	// Distance unit
	logic             dist_valid, dist_touch, dist_busy;
	logic [TAG_W-1:0] dist_tag;
	logic [AW-1:0]    wb_addr;
	logic [DEG_W-1:0] wb_deg;

	assign s_acc     = s_tvalid & s_tready;
	assign full      = (count_q >= CW'(MAX_POINTS));
	assign q_bad     = (XW'(row_f) >= XW'(count_q)) || (XW'(col_f) >= XW'(count_q));
	assign out_free  = !out_valid_q || m_tready;
	assign pipe_busy = cmp_issue_q | dist_busy;
	assign scan_done = (scan_idx_q == count_q);
	assign wb_addr   = dist_tag[TAG_W-1:DEG_W];
	assign wb_deg    = dist_tag[DEG_W-1:0];

	clb_dist #(
		.COORD_BITS (COORD_BITS),
		.TAG_W      (TAG_W)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmp_issue_q),
		.a_pt      (ref_q),
		.b_pt      (coord_rdata),
		.in_tag    ({rd_addr_q, deg_rdata}),
		.cutoff    (cutoff_q),
		.out_valid (dist_valid),
		.out_touch (dist_touch),
		.out_tag   (dist_tag),
		.busy      (dist_busy)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			clb_pkg::S_IDLE: begin
				if (s_acc) begin
					case (op)
						clb_pkg::OP_LOAD:  if (!full) state_d = clb_pkg::S_SCAN;
						clb_pkg::OP_QUERY: state_d = q_bad ? clb_pkg::S_RESP : clb_pkg::S_QREF;
						default:           state_d = clb_pkg::S_IDLE;
					endcase
				end
			end
			clb_pkg::S_SCAN:   if (scan_done) state_d = clb_pkg::S_DRAIN;
			clb_pkg::S_DRAIN:  if (!pipe_busy) state_d = clb_pkg::S_COMMIT;
			clb_pkg::S_COMMIT: state_d = clb_pkg::S_IDLE;
			clb_pkg::S_QREF:   state_d = clb_pkg::S_QCOL;
			clb_pkg::S_QCOL:   state_d = clb_pkg::S_QWAIT;
			clb_pkg::S_QWAIT:  if (dist_valid) state_d = clb_pkg::S_RESP;
			clb_pkg::S_RESP:   if (out_free) state_d = clb_pkg::S_IDLE;
			default:           state_d = clb_pkg::S_IDLE;
		endcase
	end

	// State outputs: memory ports and handshake
	always_comb begin
		s_tready  = 1'b0;
		rd_en     = 1'b0;
		rd_cmp    = 1'b0;
		rd_addr   = scan_idx_q[AW-1:0];
		coord_we  = 1'b0;
		deg_we    = 1'b0;
		deg_waddr = wb_addr;
		deg_wdata = (dist_touch && wb_deg != clb_pkg::DEG_MAX) ? wb_deg + DEG_W'(1) : wb_deg;
		unique case (state_q)
			clb_pkg::S_IDLE: s_tready = 1'b1;
			clb_pkg::S_SCAN: begin
				rd_en  = !scan_done;
				rd_cmp = !scan_done;
				deg_we = dist_valid;
			end
			clb_pkg::S_DRAIN: deg_we = dist_valid;
			clb_pkg::S_COMMIT: begin
				coord_we  = 1'b1;
				deg_we    = 1'b1;
				deg_waddr = count_q[AW-1:0];
				deg_wdata = new_deg_q;
			end
			clb_pkg::S_QREF: begin
				rd_en   = 1'b1;
				rd_addr = row_q;
			end
			clb_pkg::S_QCOL: begin
				rd_en   = 1'b1;
				rd_cmp  = 1'b1;
				rd_addr = col_q;
			end
			clb_pkg::S_QWAIT,
			clb_pkg::S_RESP: ;
			default: ;
		endcase
	end

	// Coordinate and degree memories, one read and one write port each
	always_ff @(posedge clk) begin
		if (coord_we) coord_mem[count_q[AW-1:0]] <= ref_q;
		if (rd_en)    coord_rdata <= coord_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
		if (rd_en)  deg_rdata <= deg_mem[rd_addr];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= clb_pkg::S_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			cutoff_q    <= clb_pkg::CUTOFF_RST;
			weight_q    <= clb_pkg::WEIGHT_RST;
			scan_idx_q  <= '0;
			cmp_issue_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cmp_issue_q <= rd_cmp;

			if (cfg_we) begin
				case (cfg_index)
					clb_pkg::CFG_CUTOFF: cutoff_q <= cfg_data;
					clb_pkg::CFG_WEIGHT: weight_q <= cfg_data[clb_pkg::WEIGHT_W-1:0];
					default: ;
				endcase
			end

			if (s_acc) begin
				case (op)
					clb_pkg::OP_CLEAR: begin
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
					clb_pkg::OP_LOAD: begin
						if (full) ovf_q <= 1'b1;
						scan_idx_q <= '0;
					end
					default: ;
				endcase
			end

			if (state_q == clb_pkg::S_SCAN && !scan_done) scan_idx_q <= scan_idx_q + CW'(1);
			if (state_q == clb_pkg::S_COMMIT) count_q <= count_q + CW'(1);

			if (state_q == clb_pkg::S_RESP && out_free) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		rd_addr_q <= rd_addr;

		if (s_acc) begin
			ref_q     <= pt_in;
			new_deg_q <= '0;
			row_q     <= AW'(row_f);
			col_q     <= AW'(col_f);
			diag_q    <= (row_f == col_f);
			bad_q     <= q_bad;
		end

		// new point's own degree counts every contact found in the scan, saturating at DEG_MAX
		if ((state_q == clb_pkg::S_SCAN || state_q == clb_pkg::S_DRAIN) && dist_valid &&
		    dist_touch && new_deg_q != clb_pkg::DEG_MAX)
			new_deg_q <= new_deg_q + DEG_W'(1);

		if (state_q == clb_pkg::S_QCOL) begin
			ref_q  <= coord_rdata;
			qdeg_q <= deg_rdata;
		end

		if (state_q == clb_pkg::S_QWAIT && dist_valid) touch_q <= dist_touch;

		if (state_q == clb_pkg::S_RESP && out_free) begin
			if (bad_q)       out_value_q <= '0;
			else if (diag_q) out_value_q <= EW'(qdeg_q) * EW'(weight_q);
			else if (touch_q) out_value_q <= EW'(0) - EW'(weight_q);
			else             out_value_q <= '0;
			if (bad_q)       out_status_q <= clb_pkg::STAT_BAD_INDEX;
			else if (ovf_q)  out_status_q <= clb_pkg::STAT_DROPPED;
			else             out_status_q <= clb_pkg::STAT_OK;
			out_count_q <= clb_pkg::COUNT_OUT_W'(count_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_count_q, out_status_q, out_value_q};

	// Checks
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && op == clb_pkg::OP_CLEAR) |=> (count_q == '0 && !ovf_q))
		else $error("clear did not empty the point set");

	a_full_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && op == clb_pkg::OP_LOAD && full) |=> (ovf_q && $stable(count_q)))
		else $error("load on full store not dropped and flagged");

	a_commit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == clb_pkg::S_COMMIT) |-> !pipe_busy)
		else $error("commit while compare pipe still busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == clb_pkg::S_COMMIT) |-> (count_q < CW'(MAX_POINTS)))
		else $error("commit past capacity");

endmodule
